>>> rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the i2c master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  typedef logic [2:0] delay_t;

  localparam delay_t START_TICKS     = 3'd5;
  localparam delay_t STOP_TICKS      = 3'd6;
  localparam delay_t BIT_SETUP_TICKS = 3'd1;
  localparam delay_t BIT_HALF_TICKS  = 3'd2;
  localparam delay_t ACK_LO_TICKS    = 3'd2;
  localparam delay_t ACK_HI_TICKS    = 3'd5;
  localparam delay_t RX_HOLD_TICKS   = 3'd1;
  localparam delay_t NO_TICKS        = 3'd0;

  localparam logic [2:0] BIT_LAST = 3'(BITS_PER_BYTE - 1);

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_START    = 3'd1,
    OP_STOP     = 3'd2,
    OP_SEND     = 3'd3,
    OP_WAIT_ACK = 3'd4,
    OP_READ     = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ST_A    = 4'd1,
    PH_ST_B    = 4'd2,
    PH_SP_A    = 4'd3,
    PH_SP_B    = 4'd4,
    PH_TX_SET  = 4'd5,
    PH_TX_HI   = 4'd6,
    PH_TX_LO   = 4'd7,
    PH_WA_POLL = 4'd8,
    PH_WA_HI   = 4'd9,
    PH_WA_LO   = 4'd10,
    PH_RX_LO   = 4'd11,
    PH_RX_HI   = 4'd12,
    PH_RX_HOLD = 4'd13,
    PH_AK_LO   = 4'd14,
    PH_AK_HI   = 4'd15
  } phase_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       scl_pin;
    logic       sda_pin;
  } item_t;

  typedef struct packed {
    logic       scl_drive;
    logic       sda_level;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
  } res_t;

endpackage

>>> rtl/i2cm_if.sv
// ----------------------------------------------------------------------------
// i2cm_if
// Valid/ready channels of the i2c master bit engine: tick requests,
// results and the timeout register write.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       scl_pin;
  logic       sda_pin;

  modport source (output valid, op, tx_byte, send_ack, scl_pin, sda_pin, input ready);
  modport sink (input valid, op, tx_byte, send_ack, scl_pin, sda_pin, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_drive;
  logic       sda_level;
  logic       sda_enable;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_seen;

  modport source (output valid, scl_drive, sda_level, sda_enable, busy_res, done_res,
                  rx_byte, ack_seen, input ready);
  modport sink (input valid, scl_drive, sda_level, sda_enable, busy_res, done_res,
                rx_byte, ack_seen, output ready);
endinterface

interface i2cm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] ack_timeout_ticks;

  modport source (output valid, ack_timeout_ticks, input ready);
  modport sink (input valid, ack_timeout_ticks, output ready);
endinterface

>>> rtl/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// Pin sequencer: phase, delay, bit and timeout state advanced one tick
// per enabled cycle; presents the result of the tick being taken.
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  i2cm_pkg::item_t item,
  input  logic [7:0]      ack_timeout,
  output i2cm_pkg::res_t  res
);
  import i2cm_pkg::*;

  phase_t     phase_r, phase_nxt;
  delay_t     delay_r, delay_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] tmo_r, tmo_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       oe_r, oe_nxt;
  logic       ack_flag_r, ack_flag_nxt;
  logic       ack_choice_r, ack_choice_nxt;
  logic [7:0] rx_last_r, rx_last_nxt;
  logic       done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      delay_r      <= NO_TICKS;
      bit_r        <= '0;
      shift_r      <= '0;
      tmo_r        <= '0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      oe_r         <= 1'b1;
      ack_flag_r   <= 1'b0;
      ack_choice_r <= 1'b0;
      rx_last_r    <= '0;
    end else if (en) begin
      phase_r      <= phase_nxt;
      delay_r      <= delay_nxt;
      bit_r        <= bit_nxt;
      shift_r      <= shift_nxt;
      tmo_r        <= tmo_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      oe_r         <= oe_nxt;
      ack_flag_r   <= ack_flag_nxt;
      ack_choice_r <= ack_choice_nxt;
      rx_last_r    <= rx_last_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    delay_nxt      = delay_r;
    bit_nxt        = bit_r;
    shift_nxt      = shift_r;
    tmo_nxt        = tmo_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    oe_nxt         = oe_r;
    ack_flag_nxt   = ack_flag_r;
    ack_choice_nxt = ack_choice_r;
    rx_last_nxt    = rx_last_r;
    done           = 1'b0;

    if (phase_r == PH_IDLE) begin
      case (item.op)
        OP_START: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1; oe_nxt = 1'b1;
          phase_nxt = PH_ST_A; delay_nxt = START_TICKS;
        end
        OP_STOP: begin
          scl_nxt = 1'b1; sda_nxt = 1'b0; oe_nxt = 1'b1;
          phase_nxt = PH_SP_A; delay_nxt = STOP_TICKS;
        end
        OP_SEND: begin
          shift_nxt = item.tx_byte;
          bit_nxt   = '0;
          scl_nxt = 1'b0; sda_nxt = item.tx_byte[7]; oe_nxt = 1'b1;
          phase_nxt = PH_TX_SET; delay_nxt = BIT_SETUP_TICKS;
        end
        OP_WAIT_ACK: begin
          oe_nxt    = 1'b0;
          tmo_nxt   = '0;
          phase_nxt = PH_WA_POLL; delay_nxt = NO_TICKS;
        end
        OP_READ: begin
          ack_choice_nxt = item.send_ack;
          bit_nxt   = '0;
          shift_nxt = '0;
          scl_nxt = 1'b0; oe_nxt = 1'b0;
          phase_nxt = PH_RX_LO; delay_nxt = BIT_HALF_TICKS;
        end
        default: begin
        end
      endcase
    end else if (phase_r == PH_WA_POLL) begin
      if (!item.sda_pin) begin
        ack_flag_nxt = 1'b1;
        scl_nxt   = 1'b1;
        phase_nxt = PH_WA_HI; delay_nxt = BIT_HALF_TICKS;
      end else if (tmo_r >= ack_timeout) begin
        // give up: no acknowledge, release the bus with a stop
        ack_flag_nxt = 1'b0;
        scl_nxt = 1'b1; sda_nxt = 1'b0; oe_nxt = 1'b1;
        phase_nxt = PH_SP_A; delay_nxt = STOP_TICKS;
      end else begin
        tmo_nxt = tmo_r + 8'd1;
      end
    end else if (phase_r == PH_RX_HI) begin
      // clock stretching: hold until the slave lets scl go high
      if (item.scl_pin) begin
        shift_nxt = {shift_r[6:0], item.sda_pin};
        phase_nxt = PH_RX_HOLD; delay_nxt = RX_HOLD_TICKS;
      end
    end else if (delay_r > 3'd1) begin
      delay_nxt = delay_r - 3'd1;
    end else begin
      case (phase_r)
        PH_ST_A: begin
          sda_nxt = 1'b0; phase_nxt = PH_ST_B; delay_nxt = START_TICKS;
        end
        PH_ST_B: begin
          scl_nxt = 1'b0; phase_nxt = PH_IDLE; delay_nxt = NO_TICKS; done = 1'b1;
        end
        PH_SP_A: begin
          sda_nxt = 1'b1; phase_nxt = PH_SP_B; delay_nxt = STOP_TICKS;
        end
        PH_SP_B: begin
          phase_nxt = PH_IDLE; delay_nxt = NO_TICKS; done = 1'b1;
        end
        PH_TX_SET: begin
          scl_nxt = 1'b1; phase_nxt = PH_TX_HI; delay_nxt = BIT_HALF_TICKS;
        end
        PH_TX_HI: begin
          scl_nxt = 1'b0; phase_nxt = PH_TX_LO; delay_nxt = BIT_HALF_TICKS;
        end
        PH_TX_LO: begin
          if (bit_r >= BIT_LAST) begin
            phase_nxt = PH_IDLE; delay_nxt = NO_TICKS; done = 1'b1;
          end else begin
            bit_nxt   = bit_r + 3'd1;
            shift_nxt = {shift_r[6:0], 1'b0};
            scl_nxt = 1'b0; sda_nxt = shift_r[6]; oe_nxt = 1'b1;
            phase_nxt = PH_TX_SET; delay_nxt = BIT_SETUP_TICKS;
          end
        end
        PH_WA_HI: begin
          scl_nxt = 1'b0; phase_nxt = PH_WA_LO; delay_nxt = BIT_HALF_TICKS;
        end
        PH_WA_LO: begin
          phase_nxt = PH_IDLE; delay_nxt = NO_TICKS; done = 1'b1;
        end
        PH_RX_LO: begin
          scl_nxt = 1'b1; phase_nxt = PH_RX_HI; delay_nxt = NO_TICKS;
        end
        PH_RX_HOLD: begin
          if (bit_r >= BIT_LAST) begin
            rx_last_nxt = shift_r;
            scl_nxt = 1'b0; sda_nxt = !ack_choice_r; oe_nxt = 1'b1;
            phase_nxt = PH_AK_LO; delay_nxt = ACK_LO_TICKS;
          end else begin
            bit_nxt = bit_r + 3'd1;
            scl_nxt = 1'b0;
            phase_nxt = PH_RX_LO; delay_nxt = BIT_HALF_TICKS;
          end
        end
        PH_AK_LO: begin
          scl_nxt = 1'b1; phase_nxt = PH_AK_HI; delay_nxt = ACK_HI_TICKS;
        end
        PH_AK_HI: begin
          scl_nxt = 1'b0; phase_nxt = PH_IDLE; delay_nxt = NO_TICKS; done = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE; delay_nxt = NO_TICKS;
        end
      endcase
    end
  end

  always_comb begin
    res.scl_drive  = scl_nxt;
    res.sda_enable = oe_nxt;
    // released data line reads back as high
    res.sda_level  = oe_nxt ? sda_nxt : 1'b1;
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.done_res   = done;
    res.rx_byte    = rx_last_nxt;
    res.ack_seen   = ack_flag_nxt;
  end

endmodule

>>> rtl/i2c_master_bit_engine_core.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core: a tick request passes through the input register,
// then the sequencer step into the result register, before its result is offered.
// Throughput one tick request per cycle while the result side is not stalled.
// Reset: idle, scl and sda driven high, timeout register 250.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  i2cm_in_if.sink     in_ch,
  i2cm_out_if.source  out_ch,
  i2cm_cfg_if.sink    cfg_ch
);
  import i2cm_pkg::*;

  logic       in_ready;
  logic       adv;
  logic       s1_valid_r;
  item_t      s1_item_r;
  logic       out_valid_r;
  res_t       out_res_r;
  res_t       step_res;
  logic [7:0] ack_timeout_r;

  // result register free or being emptied this cycle
  assign adv      = !out_valid_r || out_ch.ready;
  assign in_ready = adv || !s1_valid_r;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_ch.valid) begin
      ack_timeout_r <= cfg_ch.ack_timeout_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_item_r.op       <= in_ch.op;
      s1_item_r.tx_byte  <= in_ch.tx_byte;
      s1_item_r.send_ack <= in_ch.send_ack;
      s1_item_r.scl_pin  <= in_ch.scl_pin;
      s1_item_r.sda_pin  <= in_ch.sda_pin;
    end
  end

  i2cm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv && s1_valid_r),
    .item        (s1_item_r),
    .ack_timeout (ack_timeout_r),
    .res         (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.scl_drive  = out_res_r.scl_drive;
  assign out_ch.sda_level  = out_res_r.sda_level;
  assign out_ch.sda_enable = out_res_r.sda_enable;
  assign out_ch.busy_res   = out_res_r.busy_res;
  assign out_ch.done_res   = out_res_r.done_res;
  assign out_ch.rx_byte    = out_res_r.rx_byte;
  assign out_ch.ack_seen   = out_res_r.ack_seen;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.done_res |-> !out_res_r.busy_res)
    else $error("done result still reports busy");

  a_released_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.sda_enable |-> out_res_r.sda_level)
    else $error("released data line not reported high");

  a_held_request: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_item_r))
    else $error("stalled tick request dropped or changed");

  a_cfg_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(cfg_ch.valid) |-> $stable(ack_timeout_r))
    else $error("timeout register changed without a write");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the i2c master bit engine. Tick requests are
// streamed as whole command sequences, and a cycle-level model of the pin
// sequencer predicts every result. Results are compared field by field as
// they leave the block. Random gaps and stalls are applied on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import i2cm_pkg::*;

  localparam int          HOLD_CYCLES  = 150;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          RANDOM_TICKS = 200;
  localparam int          ACK_NEVER    = 32'h7fff_ffff;
  localparam logic [2:0]  OP_RSVD6     = 3'd6;
  localparam logic [2:0]  OP_RSVD7     = 3'd7;

  typedef enum int {RX_ZEROS, RX_ONES, RX_RANDOM} rx_mode_t;

  logic clk;
  logic rst_n;

  i2cm_in_if  in_ch ();
  i2cm_out_if out_ch ();
  i2cm_cfg_if cfg_ch ();

  i2c_master_bit_engine_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // sequencer model state
  logic [7:0] tmo_limit;
  phase_t     ph;
  delay_t     dly;
  logic [2:0] bit_idx;
  logic [7:0] shreg;
  logic [7:0] tmo_cnt;
  logic       p_scl;
  logic       p_sda;
  logic       p_en;
  logic       ack_flag;
  logic       ack_choice;
  logic [7:0] rx_last;

  res_t       pin_q[$];
  res_t       want;
  res_t       got;
  int         errors;
  int         ticks_sent;
  int         cycle_count;

  // stimulus shaping
  int         ack_after;
  int         polls;
  int         stretch_pct;
  int         busy_cmd_pct;
  rx_mode_t   rx_sda_mode;
  bit         quiet;
  bit         hold_req;
  int         stall_left;

  always #10 clk = ~clk;

  function automatic void enter(phase_t p, delay_t d);
    ph  = p;
    dly = d;
  endfunction

  function automatic void begin_stop();
    p_scl = 1'b1;
    p_sda = 1'b0;
    p_en  = 1'b1;
    enter(PH_SP_A, STOP_TICKS);
  endfunction

  function automatic void drive_bit();
    p_scl = 1'b0;
    p_sda = shreg[7];
    p_en  = 1'b1;
    enter(PH_TX_SET, BIT_SETUP_TICKS);
  endfunction

  function automatic res_t step_sequencer(item_t it);
    res_t r;
    logic done;
    done = 1'b0;
    if (ph == PH_IDLE) begin
      case (it.op)
        OP_START: begin
          p_scl = 1'b1;
          p_sda = 1'b1;
          p_en  = 1'b1;
          enter(PH_ST_A, START_TICKS);
        end
        OP_STOP: begin_stop();
        OP_SEND: begin
          shreg   = it.tx_byte;
          bit_idx = '0;
          drive_bit();
        end
        OP_WAIT_ACK: begin
          p_en    = 1'b0;
          tmo_cnt = '0;
          enter(PH_WA_POLL, NO_TICKS);
        end
        OP_READ: begin
          ack_choice = it.send_ack;
          bit_idx    = '0;
          shreg      = '0;
          p_scl      = 1'b0;
          p_en       = 1'b0;
          enter(PH_RX_LO, BIT_HALF_TICKS);
        end
        default: ;
      endcase
    end else if (ph == PH_WA_POLL) begin
      if (!it.sda_pin) begin
        ack_flag = 1'b1;
        p_scl    = 1'b1;
        enter(PH_WA_HI, BIT_HALF_TICKS);
      end else if (tmo_cnt >= tmo_limit) begin
        ack_flag = 1'b0;
        begin_stop();
      end else begin
        tmo_cnt = tmo_cnt + 8'd1;
      end
    end else if (ph == PH_RX_HI) begin
      // slave may stretch the clock: wait for scl high without limit
      if (it.scl_pin) begin
        shreg = {shreg[6:0], it.sda_pin};
        enter(PH_RX_HOLD, RX_HOLD_TICKS);
      end
    end else if (dly > 3'd1) begin
      dly = dly - 3'd1;
    end else begin
      case (ph)
        PH_ST_A: begin p_sda = 1'b0; enter(PH_ST_B, START_TICKS); end
        PH_ST_B: begin p_scl = 1'b0; enter(PH_IDLE, NO_TICKS); done = 1'b1; end
        PH_SP_A: begin p_sda = 1'b1; enter(PH_SP_B, STOP_TICKS); end
        PH_SP_B: begin enter(PH_IDLE, NO_TICKS); done = 1'b1; end
        PH_TX_SET: begin p_scl = 1'b1; enter(PH_TX_HI, BIT_HALF_TICKS); end
        PH_TX_HI: begin p_scl = 1'b0; enter(PH_TX_LO, BIT_HALF_TICKS); end
        PH_TX_LO: begin
          if (bit_idx >= BIT_LAST) begin
            enter(PH_IDLE, NO_TICKS);
            done = 1'b1;
          end else begin
            bit_idx = bit_idx + 3'd1;
            shreg   = shreg << 1;
            drive_bit();
          end
        end
        PH_WA_HI: begin p_scl = 1'b0; enter(PH_WA_LO, BIT_HALF_TICKS); end
        PH_WA_LO: begin enter(PH_IDLE, NO_TICKS); done = 1'b1; end
        PH_RX_LO: begin p_scl = 1'b1; enter(PH_RX_HI, NO_TICKS); end
        PH_RX_HOLD: begin
          if (bit_idx >= BIT_LAST) begin
            // byte complete: drive ack or nack on the acknowledge clock
            rx_last = shreg;
            p_scl   = 1'b0;
            p_sda   = ack_choice ? 1'b0 : 1'b1;
            p_en    = 1'b1;
            enter(PH_AK_LO, ACK_LO_TICKS);
          end else begin
            bit_idx = bit_idx + 3'd1;
            p_scl   = 1'b0;
            enter(PH_RX_LO, BIT_HALF_TICKS);
          end
        end
        PH_AK_LO: begin p_scl = 1'b1; enter(PH_AK_HI, ACK_HI_TICKS); end
        PH_AK_HI: begin p_scl = 1'b0; enter(PH_IDLE, NO_TICKS); done = 1'b1; end
        default: enter(PH_IDLE, NO_TICKS);
      endcase
    end
    r.scl_drive  = p_scl;
    r.sda_enable = p_en;
    r.sda_level  = p_en ? p_sda : 1'b1;
    r.busy_res   = (ph != PH_IDLE);
    r.done_res   = done;
    r.rx_byte    = rx_last;
    r.ack_seen   = ack_flag;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic item_t random_tick();
    item_t it;
    it.op       = ($urandom_range(0, 99) < busy_cmd_pct) ? 3'($urandom_range(1, 7)) : OP_TICK;
    it.tx_byte  = 8'($urandom);
    it.send_ack = 1'($urandom);
    it.scl_pin  = 1'($urandom);
    it.sda_pin  = 1'($urandom);
    if (ph == PH_WA_POLL) begin
      it.sda_pin = (polls >= ack_after) ? 1'b0 : 1'b1;
      polls++;
    end
    if (ph == PH_RX_HI) begin
      it.scl_pin = ($urandom_range(0, 99) >= stretch_pct);
      if (rx_sda_mode != RX_RANDOM) it.sda_pin = (rx_sda_mode == RX_ONES);
    end
    return it;
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  task automatic send_tick(input item_t it);
    int gap;
    gap = quiet ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid    = 1'b1;
    in_ch.op       = it.op;
    in_ch.tx_byte  = it.tx_byte;
    in_ch.send_ack = it.send_ack;
    in_ch.scl_pin  = it.scl_pin;
    in_ch.sda_pin  = it.sda_pin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pin_q.push_back(step_sequencer(it));
    ticks_sent++;
  endtask

  // one command request followed by random ticks until the sequence ends
  task automatic run_command(input logic [2:0] op, input logic [7:0] tx, input logic sack);
    item_t it;
    it          = random_tick();
    it.op       = op;
    it.tx_byte  = tx;
    it.send_ack = sack;
    polls       = 0;
    send_tick(it);
    while (ph != PH_IDLE) send_tick(random_tick());
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pin_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [7:0] v);
    drain_results();
    @(negedge clk);
    cfg_ch.valid             = 1'b1;
    cfg_ch.ack_timeout_ticks = v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tmo_limit = v;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic pick_policy();
    if ($urandom_range(0, 9) < 7) ack_after = $urandom_range(0, 3);
    else ack_after = $urandom_range(0, int'(tmo_limit) + 3);
    stretch_pct  = $urandom_range(0, 60);
    rx_sda_mode  = ($urandom_range(0, 9) == 0) ? rx_mode_t'($urandom_range(0, 1)) : RX_RANDOM;
    busy_cmd_pct = $urandom_range(0, 15);
  endtask

  task automatic test_reset_state();
    run_command(OP_TICK, 8'h00, 1'b0);
    run_command(OP_TICK, 8'hff, 1'b1);
  endtask

  task automatic test_start_stop();
    run_command(OP_START, 8'h00, 1'b0);
    run_command(OP_STOP, 8'h00, 1'b0);
  endtask

  task automatic test_send_bytes();
    run_command(OP_SEND, 8'h00, 1'b0);
    run_command(OP_SEND, 8'hff, 1'b1);
    run_command(OP_SEND, 8'ha5, 1'b0);
  endtask

  task automatic test_wait_ack();
    ack_after = 0;
    run_command(OP_WAIT_ACK, 8'h00, 1'b0);
    ack_after = 3;
    run_command(OP_WAIT_ACK, 8'h00, 1'b0);
    // no ack at all: times out with the reset limit and issues a stop
    ack_after = ACK_NEVER;
    run_command(OP_WAIT_ACK, 8'h00, 1'b0);
  endtask

  task automatic test_read_byte();
    rx_sda_mode = RX_ZEROS;
    stretch_pct = 0;
    run_command(OP_READ, 8'h00, 1'b1);
    rx_sda_mode = RX_ONES;
    stretch_pct = 80;
    run_command(OP_READ, 8'hff, 1'b0);
    rx_sda_mode = RX_RANDOM;
    stretch_pct = 30;
    run_command(OP_READ, 8'h5a, 1'b1);
    stretch_pct = 0;
  endtask

  task automatic test_ignored_cmds();
    busy_cmd_pct = 100;
    run_command(OP_SEND, 8'h3c, 1'b0);
    busy_cmd_pct = 0;
    run_command(OP_RSVD6, 8'h81, 1'b1);
    run_command(OP_RSVD7, 8'h7e, 1'b0);
  endtask

  task automatic test_timeout_limits();
    write_timeout(8'd1);
    ack_after = ACK_NEVER;
    run_command(OP_WAIT_ACK, 8'h00, 1'b0);
    // ack on the last poll still allowed, one later is too late
    ack_after = 1;
    run_command(OP_WAIT_ACK, 8'h00, 1'b0);
    ack_after = 2;
    run_command(OP_WAIT_ACK, 8'h00, 1'b0);
    write_timeout(8'd255);
    ack_after = ACK_NEVER;
    run_command(OP_WAIT_ACK, 8'h00, 1'b0);
    ack_after = 255;
    run_command(OP_WAIT_ACK, 8'h00, 1'b0);
    ack_after = 0;
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    quiet    = 1'b1;
    run_command(OP_SEND, 8'h96, 1'b0);
    quiet = 1'b0;
    drain_results();
  endtask

  task automatic random_transfer();
    int n;
    pick_policy();
    run_command(OP_START, 8'($urandom), 1'($urandom));
    pick_policy();
    run_command(OP_SEND, 8'($urandom), 1'($urandom));
    pick_policy();
    run_command(OP_WAIT_ACK, 8'($urandom), 1'($urandom));
    n = $urandom_range(1, 3);
    repeat (n) begin
      pick_policy();
      if ($urandom_range(0, 1)) begin
        run_command(OP_READ, 8'($urandom), 1'($urandom));
      end else begin
        run_command(OP_SEND, 8'($urandom), 1'($urandom));
        pick_policy();
        run_command(OP_WAIT_ACK, 8'($urandom), 1'($urandom));
      end
    end
    pick_policy();
    run_command(OP_STOP, 8'($urandom), 1'($urandom));
  endtask

  task automatic test_random();
    int stop_at;
    int r;
    stop_at = ticks_sent + RANDOM_TICKS;
    while (ticks_sent < stop_at) begin
      r = $urandom_range(0, 9);
      if (r == 0) write_timeout(8'd1);
      else if (r == 1) write_timeout(8'd255);
      else write_timeout(8'($urandom_range(1, 24)));
      quiet = ($urandom_range(0, 4) == 0);
      repeat (3) begin
        if ($urandom_range(0, 4) != 0) begin
          random_transfer();
        end else begin
          // loose command outside a framed transfer
          pick_policy();
          run_command(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
        end
      end
    end
    quiet = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.scl_drive  = out_ch.scl_drive;
      got.sda_level  = out_ch.sda_level;
      got.sda_enable = out_ch.sda_enable;
      got.busy_res   = out_ch.busy_res;
      got.done_res   = out_ch.done_res;
      got.rx_byte    = out_ch.rx_byte;
      got.ack_seen   = out_ch.ack_seen;
      if (pin_q.size() == 0) begin
        $display("%0t: result with no request pending: expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = pin_q.pop_front();
        check_field("scl_drive", 8'(want.scl_drive), 8'(got.scl_drive));
        check_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
        check_field("sda_enable", 8'(want.sda_enable), 8'(got.sda_enable));
        check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(got.done_res));
        check_field("rx_byte", want.rx_byte, got.rx_byte);
        check_field("ack_seen", 8'(want.ack_seen), 8'(got.ack_seen));
      end
    end
  end

  // result-side ready with random stalls and one forced long hold
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req   = 1'b0;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    clk                      = 1'b0;
    rst_n                    = 1'b0;
    in_ch.valid              = 1'b0;
    in_ch.op                 = OP_TICK;
    in_ch.tx_byte            = '0;
    in_ch.send_ack           = 1'b0;
    in_ch.scl_pin            = 1'b1;
    in_ch.sda_pin            = 1'b1;
    cfg_ch.valid             = 1'b0;
    cfg_ch.ack_timeout_ticks = '0;
    errors                   = 0;
    ticks_sent               = 0;
    cycle_count              = 0;
    quiet                    = 1'b0;
    hold_req                 = 1'b0;
    ack_after                = 0;
    polls                    = 0;
    stretch_pct              = 0;
    busy_cmd_pct             = 0;
    rx_sda_mode              = RX_RANDOM;
    tmo_limit                = ACK_TIMEOUT_RST;
    ph                       = PH_IDLE;
    dly                      = NO_TICKS;
    bit_idx                  = '0;
    shreg                    = '0;
    tmo_cnt                  = '0;
    p_scl                    = 1'b1;
    p_sda                    = 1'b1;
    p_en                     = 1'b1;
    ack_flag                 = 1'b0;
    ack_choice               = 1'b0;
    rx_last                  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_start_stop();
    test_send_bytes();
    test_wait_ack();
    test_read_byte();
    test_ignored_cmds();
    test_timeout_limits();
    test_backpressure();
    test_random();

    drain_results();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/i2cm_pkg.sv
rtl/i2cm_if.sv
rtl/i2cm_seq.sv
rtl/i2c_master_bit_engine_core.sv
bench/tb_top.sv
